// ===== rtl/hysteresis_load_shed_controller_unit_defines.svh =====
// assertion macros used by the controller unit
`ifndef HYSTERESIS_LOAD_SHED_CONTROLLER_UNIT_DEFINES_SVH
`define HYSTERESIS_LOAD_SHED_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HLSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HLSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hlsc_pkg.sv =====
`default_nettype none

package hlsc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int HOLD_W   = 20;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 20;

    // load levels
    typedef enum logic [LEVEL_W-1:0] {
        LVL_OFF = 2'd0,
        LVL_PV  = 2'd1,
        LVL_HP  = 2'd2,
        LVL_ALL = 2'd3
    } level_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PV_OFF   = 3'd0,
        REG_PV_ON    = 3'd1,
        REG_HP_OFF   = 3'd2,
        REG_HP_ON    = 3'd3,
        REG_HPPV_OFF = 3'd4,
        REG_HPPV_ON  = 3'd5,
        REG_HOLD     = 3'd6
    } reg_index_t;

    localparam logic [SAMPLE_W-1:0] PV_OFF_RST   = 12'd300;
    localparam logic [SAMPLE_W-1:0] PV_ON_RST    = 12'd700;
    localparam logic [SAMPLE_W-1:0] HP_OFF_RST   = 12'd1100;
    localparam logic [SAMPLE_W-1:0] HP_ON_RST    = 12'd1600;
    localparam logic [SAMPLE_W-1:0] HPPV_OFF_RST = 12'd1200;
    localparam logic [SAMPLE_W-1:0] HPPV_ON_RST  = 12'd2900;
    localparam logic [HOLD_W-1:0]   HOLD_RST     = 20'd1250;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pv_off;
        logic [SAMPLE_W-1:0] pv_on;
        logic [SAMPLE_W-1:0] hp_off;
        logic [SAMPLE_W-1:0] hp_on;
        logic [SAMPLE_W-1:0] hppv_off;
        logic [SAMPLE_W-1:0] hppv_on;
        logic [HOLD_W-1:0]   hold_ticks;
    } thresholds_t;

    typedef struct packed {
        level_t            level;
        logic [HOLD_W-1:0] hold;
        logic              changed;
    } decision_t;

endpackage

`default_nettype wire

// ===== rtl/hysteresis_load_shed_controller_unit.sv =====
// Battery load-shed controller: one 12-bit filtered voltage sample per request in,
// one result per sample out, in order. The sample is captured in an input register;
// from there the threshold compare and the level/countdown update run into the state and
// the result register once the result slot is free or being drained, so with m_tready high
// the block takes a sample every cycle. The throughput is one sample per cycle while the
// receiver keeps m_tready high. Thresholds and the stay-off length are written through
// the cfg port; the user must write them only while idle, the block does not enforce it.
`default_nettype none

module hysteresis_load_shed_controller_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [hlsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hlsc_pkg::CFG_W-1:0]         cfg_data,

    // sample stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,  // [11:0] sample, rest zero

    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata   // [1:0] level, [2] pv_enable,
                                                              // [3] hp_enable, [4] hppv_enable,
                                                              // [5] level_changed, [7:6] zero
);

    // configuration registers
    hlsc_pkg::thresholds_t thr_reg;

    // input stage
    logic                            in_valid_reg;
    logic [hlsc_pkg::SAMPLE_W-1:0]   sample_reg;

    // controller state
    hlsc_pkg::level_t                level_reg;
    logic [hlsc_pkg::HOLD_W-1:0]     hold_reg;

    // result register
    logic                            out_valid_reg;
    hlsc_pkg::level_t                out_level_reg;
    logic                            out_changed_reg;

    hlsc_pkg::decision_t             dec;
    logic                            proc_go;
    logic                            in_take;

    // the update stage fires when a sample is held and the result slot is free or being drained
    assign proc_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_go;
    assign in_take  = s_tvalid && s_tready;

    // register writes, out-of-range index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.pv_off     <= hlsc_pkg::PV_OFF_RST;
            thr_reg.pv_on      <= hlsc_pkg::PV_ON_RST;
            thr_reg.hp_off     <= hlsc_pkg::HP_OFF_RST;
            thr_reg.hp_on      <= hlsc_pkg::HP_ON_RST;
            thr_reg.hppv_off   <= hlsc_pkg::HPPV_OFF_RST;
            thr_reg.hppv_on    <= hlsc_pkg::HPPV_ON_RST;
            thr_reg.hold_ticks <= hlsc_pkg::HOLD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                hlsc_pkg::REG_PV_OFF:   thr_reg.pv_off     <= cfg_data[hlsc_pkg::SAMPLE_W-1:0];
                hlsc_pkg::REG_PV_ON:    thr_reg.pv_on      <= cfg_data[hlsc_pkg::SAMPLE_W-1:0];
                hlsc_pkg::REG_HP_OFF:   thr_reg.hp_off     <= cfg_data[hlsc_pkg::SAMPLE_W-1:0];
                hlsc_pkg::REG_HP_ON:    thr_reg.hp_on      <= cfg_data[hlsc_pkg::SAMPLE_W-1:0];
                hlsc_pkg::REG_HPPV_OFF: thr_reg.hppv_off   <= cfg_data[hlsc_pkg::SAMPLE_W-1:0];
                hlsc_pkg::REG_HPPV_ON:  thr_reg.hppv_on    <= cfg_data[hlsc_pkg::SAMPLE_W-1:0];
                hlsc_pkg::REG_HOLD:     thr_reg.hold_ticks <= cfg_data[hlsc_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            sample_reg <= s_tdata[hlsc_pkg::SAMPLE_W-1:0];
        end
    end

    // threshold compare and level/countdown update
    hlsc_decide u_decide (
        .sample    (sample_reg),
        .cur_level (level_reg),
        .cur_hold  (hold_reg),
        .thr       (thr_reg),
        .dec       (dec)
    );

    // state advances once per processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= hlsc_pkg::LVL_OFF;
            hold_reg  <= '0;
        end else if (proc_go) begin
            level_reg <= dec.level;
            hold_reg  <= dec.hold;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go) begin
            out_level_reg   <= dec.level;
            out_changed_reg <= dec.changed;
        end
    end

    // relay enables decoded from the registered level
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_changed_reg,
                       (out_level_reg == hlsc_pkg::LVL_ALL),
                       (out_level_reg >= hlsc_pkg::LVL_HP),
                       (out_level_reg != hlsc_pkg::LVL_OFF),
                       out_level_reg};

`include "hysteresis_load_shed_controller_unit_defines.svh"

    // a running countdown above one just counts down
    `HLSC_ASSERT_NEXT(a_hold_counts_down, aclk, aresetn, proc_go && (hold_reg > 20'd1), hold_reg == $past(hold_reg) - 1'b1, "hold countdown did not decrement")

    // no rise while the countdown still runs after this sample
    `HLSC_ASSERT_NEXT(a_no_rise_in_hold, aclk, aresetn, proc_go && (hold_reg > 20'd1), level_reg <= $past(level_reg), "level rose during hold")

    // state only moves with a processed sample
    `HLSC_ASSERT_NEXT(a_state_stable_idle, aclk, aresetn, !proc_go, $stable(level_reg) && $stable(hold_reg), "state changed without a sample")

    // a fresh result reports a change exactly when the level moved
    `HLSC_ASSERT_NEXT(a_changed_flag, aclk, aresetn, proc_go, out_changed_reg == (level_reg != $past(level_reg)), "level_changed disagrees with level update")

endmodule

`default_nettype wire

// ===== rtl/hlsc_decide.sv =====
`default_nettype none

module hlsc_decide (
    input  wire logic [hlsc_pkg::SAMPLE_W-1:0] sample,
    input  wire hlsc_pkg::level_t              cur_level,
    input  wire logic [hlsc_pkg::HOLD_W-1:0]   cur_hold,
    input  wire hlsc_pkg::thresholds_t         thr,
    output hlsc_pkg::decision_t                dec
);

    logic [hlsc_pkg::HOLD_W-1:0] hold_dec;
    hlsc_pkg::level_t            cand;
    logic                        drop;
    logic                        rise;
    logic                        hold_idle;

    always_comb begin
        hold_dec = (cur_hold != '0) ? cur_hold - 1'b1 : cur_hold;
        hold_idle = (hold_dec == '0);

        // candidate level, first matching test wins
        case (cur_level)
            hlsc_pkg::LVL_OFF: begin
                if (sample > thr.hppv_on)     cand = hlsc_pkg::LVL_ALL;
                else if (sample > thr.hp_on)  cand = hlsc_pkg::LVL_HP;
                else if (sample > thr.pv_on)  cand = hlsc_pkg::LVL_PV;
                else                          cand = hlsc_pkg::LVL_OFF;
            end
            hlsc_pkg::LVL_PV: begin
                if (sample > thr.hppv_on)     cand = hlsc_pkg::LVL_ALL;
                else if (sample > thr.hp_on)  cand = hlsc_pkg::LVL_HP;
                else if (sample < thr.pv_off) cand = hlsc_pkg::LVL_OFF;
                else                          cand = hlsc_pkg::LVL_PV;
            end
            hlsc_pkg::LVL_HP: begin
                if (sample > thr.hppv_on)     cand = hlsc_pkg::LVL_ALL;
                else if (sample < thr.pv_off) cand = hlsc_pkg::LVL_OFF;
                else if (sample < thr.hp_off) cand = hlsc_pkg::LVL_PV;
                else                          cand = hlsc_pkg::LVL_HP;
            end
            default: begin
                if (sample < thr.pv_off)        cand = hlsc_pkg::LVL_OFF;
                else if (sample < thr.hp_off)   cand = hlsc_pkg::LVL_PV;
                else if (sample < thr.hppv_off) cand = hlsc_pkg::LVL_HP;
                else                            cand = hlsc_pkg::LVL_ALL;
            end
        endcase

        drop = (cand < cur_level);
        rise = (cand > cur_level) && hold_idle;

        // a drop only arms an idle countdown
        dec.hold    = (drop && hold_idle) ? thr.hold_ticks : hold_dec;
        dec.changed = drop || rise;
        dec.level   = (drop || rise) ? cand : cur_level;
    end

endmodule

`default_nettype wire

// ===== test/hysteresis_load_shed_controller_unit_tb.sv =====
`timescale 1ns / 100ps

module hysteresis_load_shed_controller_unit_tb;

    import hlsc_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int LONG_STALL   = 64;          // receiver hold-off that fills the block
    localparam int TIMEOUT_NS   = 5_000_000;   // far beyond the slowest correct run
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 100;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // not a register, write ignored
    localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 12'hfff;
    localparam logic [HOLD_W-1:0]    HOLD_MAX   = 20'hfffff;

    // one result as the block should report it
    typedef struct {
        level_t level;
        logic   pv;
        logic   hp;
        logic   hppv;
        logic   changed;
    } shed_result_t;

    // load-shed predictor and the queue of results still owed by the block
    class shed_scoreboard;
        logic [SAMPLE_W-1:0] pv_off, pv_on, hp_off, hp_on, hppv_off, hppv_on;
        logic [HOLD_W-1:0]   hold_len;
        level_t              applied;
        logic [HOLD_W-1:0]   hold_cnt;
        shed_result_t        owed_q[$];
        int                  mismatches;
        int                  results_seen;

        function new();
            pv_off   = PV_OFF_RST;
            pv_on    = PV_ON_RST;
            hp_off   = HP_OFF_RST;
            hp_on    = HP_ON_RST;
            hppv_off = HPPV_OFF_RST;
            hppv_on  = HPPV_ON_RST;
            hold_len = HOLD_RST;
            applied  = LVL_OFF;
            hold_cnt = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_PV_OFF:   pv_off   = val[SAMPLE_W-1:0];
                REG_PV_ON:    pv_on    = val[SAMPLE_W-1:0];
                REG_HP_OFF:   hp_off   = val[SAMPLE_W-1:0];
                REG_HP_ON:    hp_on    = val[SAMPLE_W-1:0];
                REG_HPPV_OFF: hppv_off = val[SAMPLE_W-1:0];
                REG_HPPV_ON:  hppv_on  = val[SAMPLE_W-1:0];
                REG_HOLD:     hold_len = val[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted sample: advance the level and countdown, queue the result
        function void note_sample(logic [SAMPLE_W-1:0] smp);
            level_t       cand;
            shed_result_t res;
            if (hold_cnt != 0)
                hold_cnt = hold_cnt - 1'b1;
            cand = applied;
            case (applied)
                LVL_OFF: begin
                    if (smp > hppv_on)    cand = LVL_ALL;
                    else if (smp > hp_on) cand = LVL_HP;
                    else if (smp > pv_on) cand = LVL_PV;
                end
                LVL_PV: begin
                    if (smp > hppv_on)     cand = LVL_ALL;
                    else if (smp > hp_on)  cand = LVL_HP;
                    else if (smp < pv_off) cand = LVL_OFF;
                end
                LVL_HP: begin
                    if (smp > hppv_on)     cand = LVL_ALL;
                    else if (smp < pv_off) cand = LVL_OFF;
                    else if (smp < hp_off) cand = LVL_PV;
                end
                default: begin
                    if (smp < pv_off)        cand = LVL_OFF;
                    else if (smp < hp_off)   cand = LVL_PV;
                    else if (smp < hppv_off) cand = LVL_HP;
                end
            endcase
            res.changed = 1'b0;
            if (cand < applied) begin
                // a drop only arms an idle countdown
                if (hold_cnt == 0)
                    hold_cnt = hold_len;
                applied     = cand;
                res.changed = 1'b1;
            end else if (cand > applied && hold_cnt == 0) begin
                applied     = cand;
                res.changed = 1'b1;
            end
            res.level = applied;
            res.pv    = (applied >= LVL_PV);
            res.hp    = (applied >= LVL_HP);
            res.hppv  = (applied == LVL_ALL);
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] word);
            shed_result_t exp_r;
            results_seen++;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: nothing owed, got %h", results_seen, word);
                return;
            end
            exp_r = owed_q.pop_front();
            if (word[1:0] !== exp_r.level || word[2] !== exp_r.pv || word[3] !== exp_r.hp ||
                word[4] !== exp_r.hppv || word[5] !== exp_r.changed || word[7:6] !== 2'b00) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch: expected level %0d pv %b hp %b hppv %b changed %b",
                             results_seen, exp_r.level, exp_r.pv, exp_r.hp, exp_r.hppv,
                             exp_r.changed);
                    $display("    actual level %0d pv %b hp %b hppv %b changed %b pad %b",
                             word[1:0], word[2], word[3], word[4], word[5], word[7:6]);
                end
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // [11:0] sample, [15:12] zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // [1:0] level, [2] pv, [3] hp, [4] hppv, [5] changed

    shed_scoreboard shed_model;
    int             idle_pct;      // chance in percent that a side starts an idle burst
    bit             stall_req;     // asks the receiver for one long hold-off

    hysteresis_load_shed_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #CLK_HALF_NS aclk = ~aclk;

    // hard stop in case the block hangs
    initial begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: every accepted result goes to the checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shed_model.check_result(m_tdata);
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                stall_req = 1'b0;
            end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // one sample request; s_tvalid stays high between back-to-back requests
    task send_sample(input logic [SAMPLE_W-1:0] smp);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        do @(posedge aclk); while (!s_tready);
        shed_model.note_sample(smp);
    endtask

    // stop offering, wait until every owed result is back, then let the pipeline settle
    task drain();
        s_tvalid <= 1'b0;
        while (shed_model.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // leaves cfg_we high so back-to-back writes need no toggle
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        shed_model.write_reg(idx, val);
    endtask

    // all seven registers, junk in bits 19:12 of the six thresholds and a write to the unused index
    task set_regs(input logic [SAMPLE_W-1:0] pv_off, input logic [SAMPLE_W-1:0] pv_on,
                  input logic [SAMPLE_W-1:0] hp_off, input logic [SAMPLE_W-1:0] hp_on,
                  input logic [SAMPLE_W-1:0] hppv_off, input logic [SAMPLE_W-1:0] hppv_on,
                  input logic [HOLD_W-1:0] hold);
        write_reg(REG_PV_OFF,   {8'($urandom), pv_off});
        write_reg(REG_PV_ON,    {8'($urandom), pv_on});
        write_reg(REG_HP_OFF,   {8'($urandom), hp_off});
        write_reg(REG_HP_ON,    {8'($urandom), hp_on});
        write_reg(REG_HPPV_OFF, {8'($urandom), hppv_off});
        write_reg(REG_HPPV_ON,  {8'($urandom), hppv_on});
        write_reg(REG_HOLD,     hold);
        write_reg(REG_UNUSED,   20'($urandom));
        cfg_we <= 1'b0;
    endtask

    // samples cluster around the thresholds so the level actually moves
    function logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] th;
        case ($urandom_range(0, 5))
            0: th = shed_model.pv_off;
            1: th = shed_model.pv_on;
            2: th = shed_model.hp_off;
            3: th = shed_model.hp_on;
            4: th = shed_model.hppv_off;
            default: th = shed_model.hppv_on;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return th + 12'($urandom_range(0, 4)) - 12'd2;
            8:          return '0;
            9:          return SAMPLE_MAX;
            default:    return 12'($urandom);
        endcase
    endfunction

    // pick thresholds and hold length for one random phase and write them
    task random_settings();
        logic [SAMPLE_W-1:0] th [6];
        logic [SAMPLE_W-1:0] tmp;
        logic [HOLD_W-1:0]   hold;
        int                  mode;
        case ($urandom_range(0, 5))
            0:       hold = '0;
            1:       hold = 20'd1;
            2, 3:    hold = 20'($urandom_range(2, 12));
            default: hold = 20'($urandom_range(13, 60));
        endcase
        mode = $urandom_range(0, 8);
        for (int i = 0; i < 6; i++) begin
            if (mode == 8)
                th[i] = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
            else
                th[i] = 12'($urandom);
        end
        if (mode < 6) begin
            // usual ordering: pv_off <= pv_on <= hp_off <= hppv_off <= hp_on <= hppv_on
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5 - i; j++)
                    if (th[j] > th[j+1]) begin
                        tmp     = th[j];
                        th[j]   = th[j+1];
                        th[j+1] = tmp;
                    end
            set_regs(th[0], th[1], th[2], th[4], th[3], th[5], hold);
        end else begin
            // out-of-order or extreme thresholds taken as written
            set_regs(th[0], th[1], th[2], th[3], th[4], th[5], hold);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        idle_pct  = 0;
        stall_req = 1'b0;
        shed_model = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset thresholds: strict compares, climb through every level
        send_sample(12'd0);
        send_sample(12'd700);
        send_sample(12'd701);
        send_sample(12'd1600);
        send_sample(12'd1601);
        send_sample(12'd2900);
        send_sample(12'd2901);
        drain();

        // zero hold length: a rise right after a drop goes through
        set_regs(PV_OFF_RST, PV_ON_RST, HP_OFF_RST, HP_ON_RST, HPPV_OFF_RST, HPPV_ON_RST, '0);
        send_sample(12'd1200);
        send_sample(12'd1199);
        send_sample(SAMPLE_MAX);
        send_sample(12'd299);
        send_sample(SAMPLE_MAX);
        drain();

        // short hold: drop during hold keeps the count, blocked rise, then release
        set_regs(PV_OFF_RST, PV_ON_RST, HP_OFF_RST, HP_ON_RST, HPPV_OFF_RST, HPPV_ON_RST,
                 20'd3);
        send_sample(12'd1099);
        send_sample(12'd299);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(12'd300);
        send_sample(12'd1100);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0)
                set_regs('0, '0, '0, '0, '0, '0, '0);
            else if (p == 1)
                set_regs(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                         SAMPLE_MAX, 20'd5);
            else if (p == RAND_PHASES - 1)
                // longest hold last: once armed it blocks rises for the rest of the run
                set_regs(12'd300, 12'd700, 12'd1100, 12'd1600, 12'd1200, 12'd2900, HOLD_MAX);
            else
                random_settings();

            // last phase runs with no idling at all
            if (p == RAND_PHASES - 1)
                idle_pct = 0;
            else
                idle_pct = 25 * $urandom_range(0, 2);

            // one phase where the receiver stops long enough to back up the input
            if (p == 4)
                stall_req = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample());
            drain();
        end

        repeat (10) @(posedge aclk);
        if (shed_model.mismatches == 0 && shed_model.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
